// ===== hw/rtl/apvnt_pkg.sv =====
// Shared types and constants for the affine point, vector and normal transform.
`timescale 1ns / 1ps
`default_nettype none

package apvnt_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int COEF_WIDTH_DEFAULT  = 16;
   localparam int COEF_INT_BITS       = 4;
   localparam int NUM_LANES           = 3;

   localparam int CMD_WIDTH = 2;
   localparam logic [CMD_WIDTH-1:0] CMD_POINT  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_VECTOR = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_NORMAL = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_RAY    = 2'd3;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int LINEAR_WIDTH    = 48;
   localparam int TRANS_XY_WIDTH  = 64;
   localparam int TRANS_Z_WIDTH   = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW0_LINEAR  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW1_LINEAR  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW2_LINEAR  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRANSLATE_XY = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRANSLATE_Z  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_COL0 = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_COL1 = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_COL2 = 3'd7;

   localparam logic [LINEAR_WIDTH-1:0] ROW0_RESET = 48'h0000_0000_1000;
   localparam logic [LINEAR_WIDTH-1:0] ROW1_RESET = 48'h0000_1000_0000;
   localparam logic [LINEAR_WIDTH-1:0] ROW2_RESET = 48'h1000_0000_0000;

   typedef struct packed {
      logic valid;
      logic last;
   } beat_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/affine_point_vector_normal_transform.sv =====
// Top level: registers, beat issue, three component lanes and the result register.
//
//   channel | direction | handshake         | beat
//   req_    | in        | req_valid/stall   | command, in_x/y/z, dir_x/y/z
//   rsp_    | out       | rsp_valid/stall   | out_x/y/z, is_last, saturated
//   csr_    | in        | csr_valid/ready   | csr_index, csr_data
//
// One request per cycle unless results stall; a ray holds off the next request for its second beat.
// A request beat passes the issue register, a multiplier stage, an adder stage that
// also rounds and a saturation stage in each lane, and then the result register.
// Reset restores identity matrices and zero translation and empties the pipe.
// A stalled result halts the whole pipe; the result register holds its beat.
`timescale 1ns / 1ps
`default_nettype none

module affine_point_vector_normal_transform #(
   parameter int COORD_WIDTH = apvnt_pkg::COORD_WIDTH_DEFAULT,
   parameter int COEF_WIDTH  = apvnt_pkg::COEF_WIDTH_DEFAULT
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          req_valid,
   output logic                                         req_stall,
   input  wire logic [apvnt_pkg::CMD_WIDTH-1:0]         req_command,
   input  wire logic signed [COORD_WIDTH-1:0]           req_in_x,
   input  wire logic signed [COORD_WIDTH-1:0]           req_in_y,
   input  wire logic signed [COORD_WIDTH-1:0]           req_in_z,
   input  wire logic signed [COORD_WIDTH-1:0]           req_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0]           req_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0]           req_dir_z,
   output logic                                         rsp_valid,
   input  wire                                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0]                rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]                rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]                rsp_out_z,
   output logic                                         rsp_is_last,
   output logic                                         rsp_saturated,
   input  wire                                          csr_valid,
   output logic                                         csr_ready,
   input  wire logic [apvnt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [apvnt_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int NL      = apvnt_pkg::NUM_LANES;
   localparam int LIN_W   = apvnt_pkg::LINEAR_WIDTH;
   localparam int COEF_PAD = 3 * COEF_WIDTH + LIN_W;
   localparam int TRANS_PAD = 2 * COORD_WIDTH + apvnt_pkg::TRANS_XY_WIDTH;

   logic [LIN_W-1:0]                          row_ff [NL];
   logic [LIN_W-1:0]                          inv_ff [NL];
   logic [apvnt_pkg::TRANS_XY_WIDTH-1:0]      trans_xy_ff;
   logic [apvnt_pkg::TRANS_Z_WIDTH-1:0]       trans_z_ff;
   logic [TRANS_PAD-1:0]                      trans_xy_pad, trans_z_pad;
   logic [NL-1:0][COORD_WIDTH-1:0]            trans_vec;

   logic                                      advance;
   logic                                      pend_ff, pend_in;
   logic [NL-1:0][COORD_WIDTH-1:0]            dir_ff, dir_in;
   logic [NL-1:0][COORD_WIDTH-1:0]            s1_vec_ff, s1_vec_in;
   logic                                      s1_inv_ff, s1_inv_in;
   logic                                      s1_add_ff, s1_add_in;
   apvnt_pkg::beat_ctrl_type                  s1_ctrl_ff, s1_ctrl_in;
   apvnt_pkg::beat_ctrl_type                  s2_ctrl_ff, s3_ctrl_ff, s4_ctrl_ff;
   logic [NL-1:0][COORD_WIDTH-1:0]            lane_result;
   logic [NL-1:0]                             lane_sat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= apvnt_pkg::ROW0_RESET;
         row_ff[1]   <= apvnt_pkg::ROW1_RESET;
         row_ff[2]   <= apvnt_pkg::ROW2_RESET;
         inv_ff[0]   <= apvnt_pkg::ROW0_RESET;
         inv_ff[1]   <= apvnt_pkg::ROW1_RESET;
         inv_ff[2]   <= apvnt_pkg::ROW2_RESET;
         trans_xy_ff <= '0;
         trans_z_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            apvnt_pkg::CSR_ROW0_LINEAR:  row_ff[0] <= csr_data[LIN_W-1:0];
            apvnt_pkg::CSR_ROW1_LINEAR:  row_ff[1] <= csr_data[LIN_W-1:0];
            apvnt_pkg::CSR_ROW2_LINEAR:  row_ff[2] <= csr_data[LIN_W-1:0];
            apvnt_pkg::CSR_TRANSLATE_XY: begin
               trans_xy_ff <= csr_data[apvnt_pkg::TRANS_XY_WIDTH-1:0];
            end
            apvnt_pkg::CSR_TRANSLATE_Z: begin
               trans_z_ff <= csr_data[apvnt_pkg::TRANS_Z_WIDTH-1:0];
            end
            apvnt_pkg::CSR_INVERSE_COL0: inv_ff[0] <= csr_data[LIN_W-1:0];
            apvnt_pkg::CSR_INVERSE_COL1: inv_ff[1] <= csr_data[LIN_W-1:0];
            apvnt_pkg::CSR_INVERSE_COL2: inv_ff[2] <= csr_data[LIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign trans_xy_pad = TRANS_PAD'(trans_xy_ff);
   assign trans_z_pad  = TRANS_PAD'(trans_z_ff);
   assign trans_vec[0] = trans_xy_pad[0 +: COORD_WIDTH];
   assign trans_vec[1] = trans_xy_pad[COORD_WIDTH +: COORD_WIDTH];
   assign trans_vec[2] = trans_z_pad[0 +: COORD_WIDTH];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || pend_ff;

   always_comb begin
      pend_in    = pend_ff;
      dir_in     = dir_ff;
      s1_vec_in  = s1_vec_ff;
      s1_inv_in  = s1_inv_ff;
      s1_add_in  = s1_add_ff;
      s1_ctrl_in = s1_ctrl_ff;
      if (advance) begin
         if (pend_ff) begin
            s1_vec_in        = dir_ff;
            s1_inv_in        = 1'b0;
            s1_add_in        = 1'b0;
            s1_ctrl_in.valid = 1'b1;
            s1_ctrl_in.last  = 1'b1;
            pend_in          = 1'b0;
         end else if (req_valid) begin
            s1_vec_in        = {req_in_z, req_in_y, req_in_x};
            s1_inv_in        = (req_command == apvnt_pkg::CMD_NORMAL);
            s1_add_in        = (req_command == apvnt_pkg::CMD_POINT) ||
                               (req_command == apvnt_pkg::CMD_RAY);
            s1_ctrl_in.valid = 1'b1;
            s1_ctrl_in.last  = (req_command != apvnt_pkg::CMD_RAY);
            pend_in          = (req_command == apvnt_pkg::CMD_RAY);
            dir_in           = {req_dir_z, req_dir_y, req_dir_x};
         end else begin
            s1_ctrl_in.valid = 1'b0;
            s1_ctrl_in.last  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
         s4_ctrl_ff <= '0;
      end else begin
         pend_ff    <= pend_in;
         s1_ctrl_ff <= s1_ctrl_in;
         if (advance) begin
            s2_ctrl_ff <= s1_ctrl_ff;
            s3_ctrl_ff <= s2_ctrl_ff;
            s4_ctrl_ff <= s3_ctrl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_ff    <= dir_in;
      s1_vec_ff <= s1_vec_in;
      s1_inv_ff <= s1_inv_in;
      s1_add_ff <= s1_add_in;
   end

   for (genvar i = 0; i < NL; i++) begin : g_lane
      logic [COEF_PAD-1:0]    coef_pad;
      logic [COORD_WIDTH-1:0] lane_trans;

      assign coef_pad   = COEF_PAD'(s1_inv_ff ? inv_ff[i] : row_ff[i]);
      assign lane_trans = s1_add_ff ? trans_vec[i] : '0;

      apvnt_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .COEF_WIDTH  (COEF_WIDTH)
      ) u_lane (
         .clock   (clock),
         .advance (advance),
         .vec_x   ($signed(s1_vec_ff[0])),
         .vec_y   ($signed(s1_vec_ff[1])),
         .vec_z   ($signed(s1_vec_ff[2])),
         .coef_0  ($signed(coef_pad[0 +: COEF_WIDTH])),
         .coef_1  ($signed(coef_pad[COEF_WIDTH +: COEF_WIDTH])),
         .coef_2  ($signed(coef_pad[2*COEF_WIDTH +: COEF_WIDTH])),
         .trans   ($signed(lane_trans)),
         .result  (lane_result[i]),
         .sat     (lane_sat[i])
      );
   end

   apvnt_merge #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ctrl          (s4_ctrl_ff),
      .lane_result   (lane_result),
      .lane_sat      (lane_sat),
      .rsp_valid     (rsp_valid),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_is_last   (rsp_is_last),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/apvnt_lane.sv =====
// One output component: three products, sum with rounding, saturation.
`timescale 1ns / 1ps
`default_nettype none

module apvnt_lane #(
   parameter int COORD_WIDTH = apvnt_pkg::COORD_WIDTH_DEFAULT,
   parameter int COEF_WIDTH  = apvnt_pkg::COEF_WIDTH_DEFAULT
) (
   input  wire                          clock,
   input  wire                          advance,
   input  wire logic signed [COORD_WIDTH-1:0] vec_x,
   input  wire logic signed [COORD_WIDTH-1:0] vec_y,
   input  wire logic signed [COORD_WIDTH-1:0] vec_z,
   input  wire logic signed [COEF_WIDTH-1:0]  coef_0,
   input  wire logic signed [COEF_WIDTH-1:0]  coef_1,
   input  wire logic signed [COEF_WIDTH-1:0]  coef_2,
   input  wire logic signed [COORD_WIDTH-1:0] trans,
   output logic        [COORD_WIDTH-1:0] result,
   output logic                          sat
);

   localparam int FRAC   = COEF_WIDTH - apvnt_pkg::COEF_INT_BITS;
   localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_W  = PROD_W + 3;
   localparam int TOP_W  = SUM_W - FRAC - COORD_WIDTH + 1;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC - 1);
   localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [PROD_W-1:0]      prod0_ff, prod1_ff, prod2_ff;
   logic signed [PROD_W-1:0]      prod0_in, prod1_in, prod2_in;
   logic signed [COORD_WIDTH-1:0] trans_ff;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic        [COORD_WIDTH-1:0] result_ff, result_in;
   logic                          sat_ff, sat_in;
   logic        [TOP_W-1:0]       top_bits;

   assign prod0_in = PROD_W'(vec_x) * PROD_W'(coef_0);
   assign prod1_in = PROD_W'(vec_y) * PROD_W'(coef_1);
   assign prod2_in = PROD_W'(vec_z) * PROD_W'(coef_2);

   assign sum_in = SUM_W'(prod0_ff) + SUM_W'(prod1_ff) + SUM_W'(prod2_ff)
                 + (SUM_W'(trans_ff) <<< FRAC) + HALF;

   assign top_bits = sum_ff[SUM_W-1 -: TOP_W];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         result_in = sum_ff[FRAC +: COORD_WIDTH];
         sat_in    = 1'b0;
      end else begin
         result_in = sum_ff[SUM_W-1] ? NEG_MIN : POS_MAX;
         sat_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod0_ff  <= prod0_in;
         prod1_ff  <= prod1_in;
         prod2_ff  <= prod2_in;
         trans_ff  <= trans;
         sum_ff    <= sum_in;
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/apvnt_merge.sv =====
// Result register: joins the lane components and their saturation flags into one beat.
`timescale 1ns / 1ps
`default_nettype none

module apvnt_merge #(
   parameter int COORD_WIDTH = apvnt_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               advance,
   input  wire apvnt_pkg::beat_ctrl_type     ctrl,
   input  wire logic [apvnt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0] lane_result,
   input  wire logic [apvnt_pkg::NUM_LANES-1:0]                  lane_sat,
   output logic                              rsp_valid,
   output logic signed [COORD_WIDTH-1:0]     rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]     rsp_out_z,
   output logic                              rsp_is_last,
   output logic                              rsp_saturated
);

   logic                                                valid_ff;
   logic [apvnt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]    comp_ff;
   logic                                                last_ff;
   logic                                                sat_ff, sat_in;

   assign sat_in = |lane_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         comp_ff <= lane_result;
         last_ff <= ctrl.last;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_x     = $signed(comp_ff[0]);
   assign rsp_out_y     = $signed(comp_ff[1]);
   assign rsp_out_z     = $signed(comp_ff[2]);
   assign rsp_is_last   = last_ff;
   assign rsp_saturated = sat_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the affine point, vector, normal and ray transform.
`timescale 1ns / 1ps

module tb;

   localparam int COORD_W = 32;
   localparam int COEF_W = 16;
   localparam int COEF_FRAC_BITS = COEF_W - apvnt_pkg::COEF_INT_BITS;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN = 32'h8000_0000;
   localparam logic [31:0] C_NEG1 = 32'hFFFF_FFFF;
   localparam int IDLE_PCT = 26;
   localparam int HOLDOFF_AT = 400;
   localparam int HOLDOFF_CYCLES = 120;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int DRAIN_CYCLES = 10;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [apvnt_pkg::CMD_WIDTH-1:0] command;
      logic [COORD_W-1:0]   in_x;
      logic [COORD_W-1:0]   in_y;
      logic [COORD_W-1:0]   in_z;
      logic [COORD_W-1:0]   dir_x;
      logic [COORD_W-1:0]   dir_y;
      logic [COORD_W-1:0]   dir_z;
   } xform_request_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last;
      logic               sat;
   } result_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [apvnt_pkg::CMD_WIDTH-1:0] req_command = apvnt_pkg::CMD_POINT;
   logic signed [COORD_W-1:0]     req_in_x = '0;
   logic signed [COORD_W-1:0]     req_in_y = '0;
   logic signed [COORD_W-1:0]     req_in_z = '0;
   logic signed [COORD_W-1:0]     req_dir_x = '0;
   logic signed [COORD_W-1:0]     req_dir_y = '0;
   logic signed [COORD_W-1:0]     req_dir_z = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [COORD_W-1:0]     rsp_out_x;
   logic signed [COORD_W-1:0]     rsp_out_y;
   logic signed [COORD_W-1:0]     rsp_out_z;
   logic                          rsp_is_last;
   logic                          rsp_saturated;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [apvnt_pkg::CSR_INDEX_WIDTH-1:0] csr_index = apvnt_pkg::CSR_ROW0_LINEAR;
   logic [apvnt_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   xform_request_type pending_requests[$];
   result_beat_type   awaited_results[$];
   xform_request_type next_req;
   result_beat_type   want;
   logic [63:0]       matrix_file [8];

   int  queued_total = 0;
   int  items_accepted = 0;
   int  csr_writes = 0;
   int  beats_checked = 0;
   int  sat_beats = 0;
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  holdoff_left = 0;
   int  cmd_counts [4] = '{0, 0, 0, 0};
   bit  holdoff_done = 1'b0;
   bit  req_taken = 1'b0;
   bit  steady = 1'b0;
   bit  activity;
   int  phase;
   int  n;

   affine_point_vector_normal_transform #(
      .COORD_WIDTH(COORD_W),
      .COEF_WIDTH(COEF_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_in_x(req_in_x),
      .req_in_y(req_in_y),
      .req_in_z(req_in_z),
      .req_dir_x(req_dir_x),
      .req_dir_y(req_dir_y),
      .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_is_last(rsp_is_last),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic signed [COEF_W-1:0] coef_of(logic [63:0] row_bits, int k);
      return row_bits[k*COEF_W +: COEF_W];
   endfunction

   function automatic result_beat_type transform_beat(
         logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
         logic signed [COORD_W-1:0] vx, logic signed [COORD_W-1:0] vy,
         logic signed [COORD_W-1:0] vz, logic signed [COORD_W-1:0] tx,
         logic signed [COORD_W-1:0] ty, logic signed [COORD_W-1:0] tz, logic last);
      result_beat_type           res;
      logic [63:0]               rows [3];
      logic signed [COORD_W-1:0] offs [3];
      logic [COORD_W-1:0]        lane [3];
      longint                    acc;
      longint                    q;
      bit                        clipped;
      rows[0] = r0;
      rows[1] = r1;
      rows[2] = r2;
      offs[0] = tx;
      offs[1] = ty;
      offs[2] = tz;
      clipped = 1'b0;
      for (int i = 0; i < apvnt_pkg::NUM_LANES; i++) begin
         acc = longint'(coef_of(rows[i], 0)) * longint'(vx)
             + longint'(coef_of(rows[i], 1)) * longint'(vy)
             + longint'(coef_of(rows[i], 2)) * longint'(vz);
         acc = acc + (longint'(offs[i]) <<< COEF_FRAC_BITS);
         acc = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
         q = acc >>> COEF_FRAC_BITS;
         if (q > COORD_MAX) begin
            q = COORD_MAX;
            clipped = 1'b1;
         end else if (q < COORD_MIN) begin
            q = COORD_MIN;
            clipped = 1'b1;
         end
         lane[i] = q[COORD_W-1:0];
      end
      res.x = lane[0];
      res.y = lane[1];
      res.z = lane[2];
      res.last = last;
      res.sat = clipped;
      return res;
   endfunction

   function automatic void predict_request();
      logic [63:0]               r0, r1, r2;
      logic signed [COORD_W-1:0] tx, ty, tz;
      r0 = matrix_file[apvnt_pkg::CSR_ROW0_LINEAR];
      r1 = matrix_file[apvnt_pkg::CSR_ROW1_LINEAR];
      r2 = matrix_file[apvnt_pkg::CSR_ROW2_LINEAR];
      tx = matrix_file[apvnt_pkg::CSR_TRANSLATE_XY][31:0];
      ty = matrix_file[apvnt_pkg::CSR_TRANSLATE_XY][63:32];
      tz = matrix_file[apvnt_pkg::CSR_TRANSLATE_Z][31:0];
      cmd_counts[req_command]++;
      case (req_command)
         apvnt_pkg::CMD_POINT: begin
            awaited_results.push_back(transform_beat(r0, r1, r2,
               req_in_x, req_in_y, req_in_z, tx, ty, tz, 1'b1));
         end
         apvnt_pkg::CMD_VECTOR: begin
            awaited_results.push_back(transform_beat(r0, r1, r2,
               req_in_x, req_in_y, req_in_z, '0, '0, '0, 1'b1));
         end
         apvnt_pkg::CMD_NORMAL: begin
            awaited_results.push_back(transform_beat(
               matrix_file[apvnt_pkg::CSR_INVERSE_COL0],
               matrix_file[apvnt_pkg::CSR_INVERSE_COL1],
               matrix_file[apvnt_pkg::CSR_INVERSE_COL2],
               req_in_x, req_in_y, req_in_z, '0, '0, '0, 1'b1));
         end
         apvnt_pkg::CMD_RAY: begin
            awaited_results.push_back(transform_beat(r0, r1, r2,
               req_in_x, req_in_y, req_in_z, tx, ty, tz, 1'b0));
            awaited_results.push_back(transform_beat(r0, r1, r2,
               req_dir_x, req_dir_y, req_dir_z, '0, '0, '0, 1'b1));
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("%0t ns mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Drive request beats; hold a stalled beat.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pending_requests.size() > 0
                   && (steady || $urandom_range(99) >= IDLE_PCT)) begin
         next_req = pending_requests.pop_front();
         req_valid <= 1'b1;
         req_command <= next_req.command;
         req_in_x <= next_req.in_x;
         req_in_y <= next_req.in_y;
         req_in_z <= next_req.in_z;
         req_dir_x <= next_req.dir_x;
         req_dir_y <= next_req.dir_y;
         req_dir_z <= next_req.dir_z;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Stall the result channel at random outside the steady phase, with one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
         matrix_file[apvnt_pkg::CSR_ROW0_LINEAR] = 64'(apvnt_pkg::ROW0_RESET);
         matrix_file[apvnt_pkg::CSR_ROW1_LINEAR] = 64'(apvnt_pkg::ROW1_RESET);
         matrix_file[apvnt_pkg::CSR_ROW2_LINEAR] = 64'(apvnt_pkg::ROW2_RESET);
         matrix_file[apvnt_pkg::CSR_TRANSLATE_XY] = '0;
         matrix_file[apvnt_pkg::CSR_TRANSLATE_Z] = '0;
         matrix_file[apvnt_pkg::CSR_INVERSE_COL0] = 64'(apvnt_pkg::ROW0_RESET);
         matrix_file[apvnt_pkg::CSR_INVERSE_COL1] = 64'(apvnt_pkg::ROW1_RESET);
         matrix_file[apvnt_pkg::CSR_INVERSE_COL2] = 64'(apvnt_pkg::ROW2_RESET);
      end else begin
         activity = 1'b0;
         req_taken <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            matrix_file[csr_index] = csr_data;
            csr_writes <= csr_writes + 1;
            activity = 1'b1;
         end
         if (req_valid && !req_stall) begin
            predict_request();
            items_accepted <= items_accepted + 1;
            activity = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            activity = 1'b1;
            beats_checked++;
            if (rsp_saturated === 1'b1)
               sat_beats++;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected beat x=%h y=%h z=%h",
                  rsp_out_x, rsp_out_y, rsp_out_z));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_out_x !== want.x)
                  report_mismatch($sformatf("out_x %h, want %h", rsp_out_x, want.x));
               if (rsp_out_y !== want.y)
                  report_mismatch($sformatf("out_y %h, want %h", rsp_out_y, want.y));
               if (rsp_out_z !== want.z)
                  report_mismatch($sformatf("out_z %h, want %h", rsp_out_z, want.z));
               if (rsp_is_last !== want.last)
                  report_mismatch($sformatf("is_last %b, want %b", rsp_is_last, want.last));
               if (rsp_saturated !== want.sat)
                  report_mismatch($sformatf("saturated %b, want %b", rsp_saturated, want.sat));
            end
         end
         if (activity) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return C_MAX;
         1: return C_MIN;
         2: return 32'h0;
         3: return C_NEG1;
         default: return 32'h1;
      endcase
   endfunction

   function automatic logic [31:0] random_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0, 1: return r;
         2: return pick_extreme();
         default: return {{8{r[23]}}, r[23:0]};
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
      endcase
   endfunction

   function automatic logic [63:0] random_linear();
      return {16'($urandom), random_coef(), random_coef(), random_coef()};
   endfunction

   task automatic queue_item(input logic [apvnt_pkg::CMD_WIDTH-1:0] cmd,
         input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
         input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz);
      pending_requests.push_back('{command: cmd, in_x: x, in_y: y, in_z: z,
                                   dir_x: dx, dir_y: dy, dir_z: dz});
      queued_total++;
   endtask

   task automatic write_register(input logic [apvnt_pkg::CSR_INDEX_WIDTH-1:0] idx,
         input logic [63:0] value);
      int start_count;
      start_count = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (csr_writes == start_count);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (items_accepted != queued_total || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      queue_item(apvnt_pkg::CMD_POINT, C_MAX, C_MIN, 32'h0, $urandom, $urandom, $urandom);
      queue_item(apvnt_pkg::CMD_VECTOR, C_NEG1, 32'h1, C_MAX, $urandom, $urandom, $urandom);
      queue_item(apvnt_pkg::CMD_NORMAL, C_MIN, C_MAX, C_NEG1,
                 $urandom, $urandom, $urandom);
      queue_item(apvnt_pkg::CMD_RAY, C_MAX, C_MIN, 32'h1, C_MIN, C_MAX, 32'h0);
      queue_item(apvnt_pkg::CMD_RAY, 32'h0, 32'h0, 32'h0, C_NEG1, 32'h0001_8000, C_MIN);
      wait_for_drain();

      write_register(apvnt_pkg::CSR_ROW0_LINEAR, {16'h0, {3{16'h7FFF}}});
      write_register(apvnt_pkg::CSR_ROW1_LINEAR, {16'hFFFF, {3{16'h8000}}});
      write_register(apvnt_pkg::CSR_ROW2_LINEAR, {16'h0, 16'h8000, 16'h7FFF, 16'h0001});
      write_register(apvnt_pkg::CSR_TRANSLATE_XY, {C_MIN, C_MAX});
      write_register(apvnt_pkg::CSR_TRANSLATE_Z, {32'hDEAD_BEEF, C_MAX});
      write_register(apvnt_pkg::CSR_INVERSE_COL0, {16'h0, {3{16'hFFFF}}});
      write_register(apvnt_pkg::CSR_INVERSE_COL1, {16'h0, 16'h7FFF, 16'h0000, 16'h8000});
      write_register(apvnt_pkg::CSR_INVERSE_COL2, 64'h0);
      queue_item(apvnt_pkg::CMD_POINT, C_MAX, C_MAX, C_MAX, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_POINT, C_MIN, C_MIN, C_MIN, C_NEG1, C_NEG1, C_NEG1);
      queue_item(apvnt_pkg::CMD_POINT, 32'h0, 32'h0, 32'h0, C_MAX, C_MIN, C_MAX);
      queue_item(apvnt_pkg::CMD_POINT, 32'h1, C_NEG1, 32'h100,
                 $urandom, $urandom, $urandom);
      queue_item(apvnt_pkg::CMD_VECTOR, C_MAX, C_MIN, C_MAX, $urandom, $urandom, $urandom);
      queue_item(apvnt_pkg::CMD_VECTOR, 32'h0000_1000, C_NEG1, 32'h2,
                 C_MAX, C_MAX, C_MAX);
      queue_item(apvnt_pkg::CMD_NORMAL, C_MAX, C_MAX, C_MAX, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_NORMAL, C_MIN, 32'h1, C_NEG1,
                 $urandom, $urandom, $urandom);
      queue_item(apvnt_pkg::CMD_RAY, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX);
      queue_item(apvnt_pkg::CMD_RAY, 32'h1, 32'h2, 32'h3, C_NEG1, 32'h0, 32'h10);
      wait_for_drain();

      // half-weight coefficients put odd inputs on rounding ties
      write_register(apvnt_pkg::CSR_ROW0_LINEAR, {16'h0, 16'h0000, 16'h0000, 16'h0800});
      write_register(apvnt_pkg::CSR_ROW1_LINEAR, {16'h0, {3{16'h0800}}});
      write_register(apvnt_pkg::CSR_ROW2_LINEAR, {16'h0, 16'hF800, 16'h0000, 16'h0000});
      write_register(apvnt_pkg::CSR_TRANSLATE_XY, {C_NEG1, 32'h1});
      write_register(apvnt_pkg::CSR_TRANSLATE_Z, 64'h0);
      write_register(apvnt_pkg::CSR_INVERSE_COL0, {16'h0, 16'h0000, 16'h0000, 16'hF800});
      write_register(apvnt_pkg::CSR_INVERSE_COL1, {16'h0, 16'h0000, 16'h0800, 16'h0000});
      write_register(apvnt_pkg::CSR_INVERSE_COL2, {16'h0, 16'h0800, 16'h0000, 16'h0000});
      queue_item(apvnt_pkg::CMD_POINT, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_POINT, C_NEG1, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_VECTOR, 32'h1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_VECTOR, C_NEG1, C_NEG1, C_NEG1, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_NORMAL, 32'h1, C_NEG1, 32'h3, 32'h0, 32'h0, 32'h0);
      queue_item(apvnt_pkg::CMD_RAY, 32'h1, 32'h3, 32'h5,
                 C_NEG1, 32'hFFFF_FFFD, 32'hFFFF_FFFB);
      wait_for_drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady <= (phase == 3);
         write_register(apvnt_pkg::CSR_ROW0_LINEAR, random_linear());
         write_register(apvnt_pkg::CSR_ROW1_LINEAR, random_linear());
         write_register(apvnt_pkg::CSR_ROW2_LINEAR, random_linear());
         write_register(apvnt_pkg::CSR_TRANSLATE_XY, {random_coord(), random_coord()});
         write_register(apvnt_pkg::CSR_TRANSLATE_Z, {32'($urandom), random_coord()});
         write_register(apvnt_pkg::CSR_INVERSE_COL0, random_linear());
         write_register(apvnt_pkg::CSR_INVERSE_COL1, random_linear());
         write_register(apvnt_pkg::CSR_INVERSE_COL2, random_linear());
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            queue_item(2'($urandom_range(0, 3)), random_coord(), random_coord(),
                       random_coord(), random_coord(), random_coord(), random_coord());
         wait_for_drain();
      end
      steady <= 1'b0;
      repeat (2 * DRAIN_CYCLES) @(negedge clock);

      $display("summary: %0d requests (%0d point, %0d vector, %0d normal, %0d ray)",
               items_accepted, cmd_counts[apvnt_pkg::CMD_POINT],
               cmd_counts[apvnt_pkg::CMD_VECTOR], cmd_counts[apvnt_pkg::CMD_NORMAL],
               cmd_counts[apvnt_pkg::CMD_RAY]);
      $display("summary: %0d result beats, %0d saturated, %0d register writes, %0d errors",
               beats_checked, sat_beats, csr_writes, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/apvnt_pkg.sv
hw/rtl/apvnt_lane.sv
hw/rtl/apvnt_merge.sv
hw/rtl/affine_point_vector_normal_transform.sv
tb/tb.sv
